// ===== src/glbdf_pkg.sv =====
// ----------------------------------------------------------------------------
// glbdf_pkg
// Shared constants and types of the binary glTF container deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package glbdf_pkg;

    localparam logic [31:0] MAGIC_GLTF  = 32'h4654_6C67;
    localparam logic [31:0] TYPE_JSON   = 32'h4E4F_534A;
    localparam logic [31:0] TYPE_BIN    = 32'h004E_4942;
    localparam logic [31:0] GLB_VERSION = 32'd2;

    // byte offsets within the 12-byte file header
    localparam logic [31:0] POS_MAGIC_END   = 32'd3;
    localparam logic [31:0] POS_VERSION_END = 32'd7;
    localparam logic [31:0] POS_HDR_END     = 32'd11;
    localparam logic [32:0] FILE_HDR_LEN    = 33'd12;
    localparam logic [33:0] CHUNK_HDR_LEN   = 34'd8;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_LENGTH  = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;
    localparam logic [2:0] ST_NOJSON  = 3'd6;

    // output channel codes
    localparam logic CH_JSON = 1'b0;
    localparam logic CH_BIN  = 1'b1;

    typedef struct packed {
        logic        byte_valid;
        logic        channel;
        logic [7:0]  out_byte;
        logic [15:0] bin_chunk_number;
        logic        done_res;
        logic [2:0]  status;
    } t_result;

endpackage

`default_nettype wire

// ===== src/glbdf_in_if.sv =====
// ----------------------------------------------------------------------------
// glbdf_in_if
// Byte stream channel into the deframer: one file byte and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface glbdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== src/glbdf_out_if.sv =====
// ----------------------------------------------------------------------------
// glbdf_out_if
// Result channel out of the deframer: payload byte, tags and final status.
// ----------------------------------------------------------------------------
`default_nettype none

interface glbdf_out_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic        channel;
    logic [7:0]  out_byte;
    logic [15:0] bin_chunk_number;
    logic        done_res;
    logic [2:0]  status;

    modport source (output valid, output byte_valid, output channel, output out_byte,
                    output bin_chunk_number, output done_res, output status,
                    input ready);
    modport sink   (input valid, input byte_valid, input channel, input out_byte,
                    input bin_chunk_number, input done_res, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== src/glbdf_parser.sv =====
// ----------------------------------------------------------------------------
// glbdf_parser
// Parse state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module glbdf_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_is_last,
    output glbdf_pkg::t_result      o_result
);

    localparam logic [1:0] PH_FILE_HDR  = 2'd0;
    localparam logic [1:0] PH_CHUNK_HDR = 2'd1;
    localparam logic [1:0] PH_PAYLOAD   = 2'd2;
    localparam logic [1:0] PH_SKIP      = 2'd3;

    localparam logic [1:0] CL_JSON = 2'd0;
    localparam logic [1:0] CL_BIN  = 2'd1;
    localparam logic [1:0] CL_SKIP = 2'd2;

    logic [31:0] r_pos,   n_pos;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_decl,  n_decl;
    logic [31:0] r_rem,   n_rem;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_idx,   n_idx;
    logic [1:0]  r_cls,   n_cls;
    logic        r_json,  n_json;
    logic [2:0]  r_err,   n_err;
    logic [15:0] r_bin,   n_bin;

    logic [31:0] w_shift;
    logic [32:0] w_next_off;
    logic        w_fits;
    logic        w_end_chunk;
    logic        w_valid;
    logic        w_chan;
    logic [7:0]  w_obyte;
    logic [2:0]  w_status;

    assign w_shift    = {i_data_byte, r_shift[31:8]};
    assign w_next_off = {1'b0, r_pos} + 33'd1;
    assign n_pos      = (r_pos == 32'hFFFF_FFFF) ? r_pos : w_next_off[31:0];
    assign n_decl     = (r_phase == PH_FILE_HDR && r_pos == glbdf_pkg::POS_HDR_END)
                        ? w_shift : r_decl;
    // room for another chunk header before the declared end
    assign w_fits     = ({1'b0, w_next_off} + glbdf_pkg::CHUNK_HDR_LEN) <= {2'b00, n_decl};

    always_comb begin
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_cls       = r_cls;
        n_json      = r_json;
        n_err       = r_err;
        n_bin       = r_bin;
        w_valid     = 1'b0;
        w_chan      = glbdf_pkg::CH_JSON;
        w_obyte     = 8'd0;
        w_end_chunk = 1'b0;

        unique case (r_phase)
            PH_FILE_HDR: begin
                n_shift = w_shift;
                if (r_pos == glbdf_pkg::POS_MAGIC_END && w_shift != glbdf_pkg::MAGIC_GLTF
                        && r_err == glbdf_pkg::ST_OK) begin
                    n_err = glbdf_pkg::ST_MAGIC;
                end
                if (r_pos == glbdf_pkg::POS_VERSION_END && w_shift != glbdf_pkg::GLB_VERSION
                        && r_err == glbdf_pkg::ST_OK) begin
                    n_err = glbdf_pkg::ST_VERSION;
                end
                if (r_pos == glbdf_pkg::POS_HDR_END) begin
                    w_end_chunk = 1'b1;
                end
            end
            PH_CHUNK_HDR: begin
                n_shift = w_shift;
                n_idx   = r_idx + 3'd1;
                if (n_idx == 3'd4) begin
                    n_rem = w_shift;
                end else if (n_idx == 3'd0) begin
                    if (!r_json) begin
                        if (w_shift == glbdf_pkg::TYPE_JSON) begin
                            n_cls  = CL_JSON;
                            n_json = 1'b1;
                        end else begin
                            n_cls = CL_SKIP;
                            n_err = glbdf_pkg::ST_NOJSON;
                        end
                    end else if (w_shift == glbdf_pkg::TYPE_BIN) begin
                        n_cls = CL_BIN;
                        if (r_bin != 16'hFFFF) begin
                            n_bin = r_bin + 16'd1;
                        end
                    end else begin
                        n_cls = CL_SKIP;
                    end
                    if (r_rem == 32'd0) begin
                        w_end_chunk = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_err == glbdf_pkg::ST_OK && (r_cls == CL_JSON || r_cls == CL_BIN)) begin
                    w_valid = 1'b1;
                    w_chan  = (r_cls == CL_BIN) ? glbdf_pkg::CH_BIN : glbdf_pkg::CH_JSON;
                    w_obyte = i_data_byte;
                end
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    w_end_chunk = 1'b1;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        if (w_end_chunk) begin
            if (n_err != glbdf_pkg::ST_OK) begin
                n_phase = PH_SKIP;
            end else if (w_fits) begin
                n_phase = PH_CHUNK_HDR;
                n_idx   = 3'd0;
            end else begin
                n_phase = PH_SKIP;
            end
        end
    end

    // final status, by priority
    always_comb begin
        w_status = glbdf_pkg::ST_OK;
        if (i_is_last) begin
            if (w_next_off < glbdf_pkg::FILE_HDR_LEN) begin
                w_status = glbdf_pkg::ST_SHORT;
            end else if (n_err == glbdf_pkg::ST_MAGIC || n_err == glbdf_pkg::ST_VERSION) begin
                w_status = n_err;
            end else if ({1'b0, n_decl} > w_next_off) begin
                w_status = glbdf_pkg::ST_LENGTH;
            end else if (n_phase == PH_PAYLOAD && n_rem != 32'd0) begin
                w_status = glbdf_pkg::ST_OVERRUN;
            end else if (n_err == glbdf_pkg::ST_NOJSON || !n_json) begin
                w_status = glbdf_pkg::ST_NOJSON;
            end
        end
    end

    always_comb begin
        o_result.byte_valid       = w_valid;
        o_result.channel          = w_chan;
        o_result.out_byte         = w_obyte;
        o_result.bin_chunk_number = n_bin;
        o_result.done_res         = i_is_last;
        o_result.status           = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_is_last)) begin
            // reset or end of file: start afresh for the next one
            r_pos   <= '0;
            r_shift <= '0;
            r_decl  <= '0;
            r_rem   <= '0;
            r_phase <= PH_FILE_HDR;
            r_idx   <= '0;
            r_cls   <= CL_JSON;
            r_json  <= 1'b0;
            r_err   <= glbdf_pkg::ST_OK;
            r_bin   <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_decl  <= n_decl;
            r_rem   <= n_rem;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cls   <= n_cls;
            r_json  <= n_json;
            r_err   <= n_err;
            r_bin   <= n_bin;
        end
    end

endmodule

`default_nettype wire

// ===== src/glbdf_out_reg.sv =====
// ----------------------------------------------------------------------------
// glbdf_out_reg
// Result register between the parse logic and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module glbdf_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire glbdf_pkg::t_result i_result,
    output logic                    o_space,
    glbdf_out_if.source             o_out
);

    logic               r_valid;
    glbdf_pkg::t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.byte_valid       = r_result.byte_valid;
    assign o_out.channel          = r_result.channel;
    assign o_out.out_byte         = r_result.out_byte;
    assign o_out.bin_chunk_number = r_result.bin_chunk_number;
    assign o_out.done_res         = r_result.done_res;
    assign o_out.status           = r_result.status;

endmodule

`default_nettype wire

// ===== src/glb_container_deframer.sv =====
// ----------------------------------------------------------------------------
// glb_container_deframer
// Streaming deframer for binary glTF containers, one file byte per word.
// ----------------------------------------------------------------------------
// Input channel i_in carries one file byte and a last flag per word. Output
// channel o_out carries exactly one result word per input word: a payload byte
// tagged JSON or BIN (byte_valid), the running BIN chunk count, and on the word
// for the last byte done_res with the file status.
// The result for a byte is registered when the byte is accepted and presented
// in the cycle after. Throughput: one byte per cycle while the receiver takes
// each word; the parse state updates per accepted byte and the result register holds one word.
// i_in.ready is high while the result register is empty or its word is being
// taken, so a stalled receiver holds the word and back-pressures the input
// after one word without losing or repeating any.
// Reset clears the parse state and empties the result register; the block
// is ready in the first cycle after reset. After the last byte of a file the
// parse state returns to its reset value, so the next byte starts a new file.
// The receiver discards a file's output when its final status is not ok.
// ----------------------------------------------------------------------------
`default_nettype none

module glb_container_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    glbdf_in_if.sink        i_in,
    glbdf_out_if.source     o_out
);

    logic               w_space;
    logic               w_accept;
    glbdf_pkg::t_result w_result;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    glbdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_is_last   (i_in.is_last),
        .o_result    (w_result)
    );

    glbdf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== test/glbdf_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glbdf_result_checker
// Watches both channels of the deframer, predicts every result word from the
// accepted file bytes and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

module glbdf_result_checker
    import glbdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    glbdf_in_if  i_in_ch,
    glbdf_out_if i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [1:0] {PH_FILE_HDR, PH_CHUNK_HDR, PH_PAYLOAD, PH_SKIP} t_phase;
    typedef enum logic [1:0] {CL_JSON, CL_BIN, CL_SKIP} t_class;

    logic [31:0] pos;
    logic [31:0] hdr_shift;
    logic [31:0] decl_len;
    logic [31:0] remain;
    t_phase      phase;
    logic [2:0]  hdr_idx;
    t_class      cls;
    logic        json_seen;
    logic [2:0]  err;
    logic [15:0] bin_cnt;

    t_result predicted_results[$];
    int      fail_total    = 0;
    int      pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    task automatic clear_parse();
        pos       = '0;
        hdr_shift = '0;
        decl_len  = '0;
        remain    = '0;
        phase     = PH_FILE_HDR;
        hdr_idx   = '0;
        cls       = CL_JSON;
        json_seen = 1'b0;
        err       = ST_OK;
        bin_cnt   = '0;
    endtask

    // next_off is the index of the byte after the one just taken
    task automatic finish_chunk(input logic [63:0] next_off);
        if (err != ST_OK) begin
            phase = PH_SKIP;
        end else if (next_off + 64'(CHUNK_HDR_LEN) <= {32'd0, decl_len}) begin
            phase   = PH_CHUNK_HDR;
            hdr_idx = '0;
        end else begin
            phase = PH_SKIP;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic last, output t_result r);
        logic [63:0] size;
        r    = '0;
        size = {32'd0, pos} + 64'd1;
        case (phase)
            PH_FILE_HDR: begin
                hdr_shift = {b, hdr_shift[31:8]};
                if (pos == POS_MAGIC_END && hdr_shift != MAGIC_GLTF && err == ST_OK)
                    err = ST_MAGIC;
                if (pos == POS_VERSION_END && hdr_shift != GLB_VERSION && err == ST_OK)
                    err = ST_VERSION;
                if (pos == POS_HDR_END) begin
                    decl_len = hdr_shift;
                    finish_chunk(size);
                end
            end
            PH_CHUNK_HDR: begin
                hdr_shift = {b, hdr_shift[31:8]};
                hdr_idx   = hdr_idx + 3'd1;
                if (hdr_idx == 3'd4) begin
                    remain = hdr_shift;
                end else if (hdr_idx == 3'd0) begin
                    // first chunk decides json; a rejected one is still length-tracked
                    if (!json_seen) begin
                        if (hdr_shift == TYPE_JSON) begin
                            cls       = CL_JSON;
                            json_seen = 1'b1;
                        end else begin
                            cls = CL_SKIP;
                            err = ST_NOJSON;
                        end
                    end else if (hdr_shift == TYPE_BIN) begin
                        cls = CL_BIN;
                        if (bin_cnt != 16'hFFFF)
                            bin_cnt = bin_cnt + 16'd1;
                    end else begin
                        cls = CL_SKIP;
                    end
                    if (remain == '0)
                        finish_chunk(size);
                    else
                        phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (err == ST_OK && cls != CL_SKIP) begin
                    r.byte_valid = 1'b1;
                    r.channel    = (cls == CL_BIN) ? CH_BIN : CH_JSON;
                    r.out_byte   = b;
                end
                remain = remain - 32'd1;
                if (remain == '0)
                    finish_chunk(size);
            end
            default: phase = PH_SKIP;
        endcase

        if (pos != 32'hFFFF_FFFF)
            pos = pos + 32'd1;

        r.bin_chunk_number = bin_cnt;
        r.done_res         = last;
        if (last) begin
            if (size < 64'(FILE_HDR_LEN))
                r.status = ST_SHORT;
            else if (err == ST_MAGIC || err == ST_VERSION)
                r.status = err;
            else if ({32'd0, decl_len} > size)
                r.status = ST_LENGTH;
            else if (phase == PH_PAYLOAD && remain != '0)
                r.status = ST_OVERRUN;
            else if (err == ST_NOJSON || !json_seen)
                r.status = ST_NOJSON;
            else
                r.status = ST_OK;
            clear_parse();
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            predicted_results.delete();
            clear_parse();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.byte_valid       = i_out_ch.byte_valid;
                got.channel          = i_out_ch.channel;
                got.out_byte         = i_out_ch.out_byte;
                got.bin_chunk_number = i_out_ch.bin_chunk_number;
                got.done_res         = i_out_ch.done_res;
                got.status           = i_out_ch.status;
                if (predicted_results.size() == 0) begin
                    $error("result word with no byte outstanding");
                    fail_total++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
                    check_field("channel", 16'(want.channel), 16'(got.channel));
                    check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
                    check_field("bin_chunk_number", want.bin_chunk_number,
                                got.bin_chunk_number);
                    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                    check_field("status", 16'(want.status), 16'(got.status));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                deframe_byte(i_in_ch.data_byte, i_in_ch.is_last, want);
                predicted_results.push_back(want);
            end
        end
        pending_count = predicted_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds the deframer whole container files, mostly well formed with random
// chunks and payloads, some damaged, under varying sender and receiver idling.
// ----------------------------------------------------------------------------

module tb;
    import glbdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 325;

    logic i_clk = 1'b0;
    logic i_rst_n;

    glbdf_in_if  in_ch ();
    glbdf_out_if out_ch ();

    int fail_count;
    int pending;
    int src_idle_pct;
    int stall_pct;
    int bytes_sent;
    int idle_cycles;

    logic [7:0] glb_file[$];

    glb_container_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    glbdf_result_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic put_word(input logic [31:0] w);
        glb_file.push_back(w[7:0]);
        glb_file.push_back(w[15:8]);
        glb_file.push_back(w[23:16]);
        glb_file.push_back(w[31:24]);
    endtask

    task automatic set_declared_length(input logic [31:0] len);
        glb_file[8]  = len[7:0];
        glb_file[9]  = len[15:8];
        glb_file[10] = len[23:16];
        glb_file[11] = len[31:24];
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (glb_file[i])
            send_byte(glb_file[i], i == glb_file.size() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic compose_file();
        int          n_chunks;
        int          plen;
        int          roll;
        int          keep;
        int          idx;
        logic [31:0] ctype;
        logic [31:0] len_field;
        glb_file.delete();
        put_word(MAGIC_GLTF);
        put_word(GLB_VERSION);
        put_word(32'd0);
        n_chunks = $urandom_range(0, 4);
        for (int c = 0; c < n_chunks; c++) begin
            roll = $urandom_range(0, 99);
            if (c == 0)
                ctype = (roll < 85) ? TYPE_JSON : (roll < 93) ? TYPE_BIN : $urandom();
            else
                ctype = (roll < 55) ? TYPE_BIN : (roll < 65) ? TYPE_JSON : $urandom();
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            // now and then a length that runs far past the file
            len_field = ($urandom_range(0, 19) == 0) ? $urandom() : plen;
            put_word(len_field);
            put_word(ctype);
            repeat (plen) glb_file.push_back(8'($urandom_range(0, 255)));
        end
        set_declared_length(glb_file.size());
        case ($urandom_range(0, 11))
            0, 1: begin
                idx = $urandom_range(0, glb_file.size() - 1);
                glb_file[idx] = glb_file[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            2: begin
                keep = $urandom_range(1, glb_file.size());
                while (glb_file.size() > keep) void'(glb_file.pop_back());
            end
            3: repeat ($urandom_range(1, 10)) glb_file.push_back(8'($urandom_range(0, 255)));
            4: set_declared_length($urandom_range(0, glb_file.size() + 8));
            5: set_declared_length($urandom());
            default: ;
        endcase
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        src_idle_pct    = 0;
        stall_pct       = 0;
        bytes_sent      = 0;
        idle_cycles     = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one-byte file: too short for a header
        glb_file.delete();
        glb_file.push_back(8'hFF);
        send_file();

        // good file with one JSON and one BIN byte of payload
        glb_file.delete();
        put_word(MAGIC_GLTF);
        put_word(GLB_VERSION);
        put_word(32'd30);
        put_word(32'd1);
        put_word(TYPE_JSON);
        glb_file.push_back(8'h00);
        put_word(32'd1);
        put_word(TYPE_BIN);
        glb_file.push_back(8'hFF);
        send_file();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  stall_pct = 0;  end
                1: begin src_idle_pct = 66; stall_pct = 0;  end
                2: begin src_idle_pct = 0;  stall_pct = 66; end
                default: begin src_idle_pct = 33; stall_pct = 33; end
            endcase
            while (bytes_sent < (ph + 1) * PHASE_BYTES) begin
                compose_file();
                send_file();
            end
            // hold the sender back until the receiver has everything
            wait_drained();
        end

        stall_pct = 0;
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
